/* hw/rtl/scns_pkg.sv */
// Shared types and constants for the sector corner nearest-site search.
package scns_pkg;

  // Field widths
  localparam int COORD_BITS    = 12;
  localparam int COLOR_BITS    = 24;
  localparam int SLOT_BITS     = 4;
  localparam int COUNT_BITS    = 5;
  localparam int DEF_MAX_SITES = 16;

  // Corner coordinates span -(2^C-1) .. 2^(C+1)-3, so C+2 signed bits
  localparam int CORNER_BITS = COORD_BITS + 2;
  // Largest corner-to-site offset magnitude is 2^(C+1)-2
  localparam int MAG_BITS    = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * MAG_BITS;
  localparam int DIST_BITS   = 2 * COORD_BITS + 3;

  localparam int NUM_CORNERS = 4;

  // Request kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [SLOT_BITS-1:0]  site_slot;
    logic [COORD_BITS-1:0] site_x;
    logic [COORD_BITS-1:0] site_y;
    logic [COLOR_BITS-1:0] site_color;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;
  } scns_in_t;

  typedef struct packed {
    logic                  valid_res;
    logic [SLOT_BITS-1:0]  nw_index;
    logic [SLOT_BITS-1:0]  ne_index;
    logic [SLOT_BITS-1:0]  sw_index;
    logic [SLOT_BITS-1:0]  se_index;
    logic [COLOR_BITS-1:0] nw_color;
    logic [COLOR_BITS-1:0] ne_color;
    logic [COLOR_BITS-1:0] sw_color;
    logic [COLOR_BITS-1:0] se_color;
    logic                  all_same;
  } scns_out_t;

  // One stored site
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
  } scns_site_t;

  // Corner edges of the sector being scanned
  typedef struct packed {
    logic signed [CORNER_BITS-1:0] lo_x;
    logic signed [CORNER_BITS-1:0] hi_x;
    logic signed [CORNER_BITS-1:0] lo_y;
    logic signed [CORNER_BITS-1:0] hi_y;
  } scns_corners_t;

  // Squared offsets of one site from the corner edges
  typedef struct packed {
    logic [SQ_BITS-1:0]    sq_xlo;
    logic [SQ_BITS-1:0]    sq_xhi;
    logic [SQ_BITS-1:0]    sq_ylo;
    logic [SQ_BITS-1:0]    sq_yhi;
    logic [COLOR_BITS-1:0] color;
  } scns_sq_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } scns_state_t;

endpackage

/* hw/rtl/scns_site_cell.sv */
// One site cell of the rotating site ring: load in place or take the neighbor's site.
module scns_site_cell (
  input  logic               clk,
  input  logic               load_en,
  input  scns_pkg::scns_site_t load_site,
  input  logic               shift_en,
  input  scns_pkg::scns_site_t next_site,
  output scns_pkg::scns_site_t site
);
  import scns_pkg::*;

  scns_site_t site_r;

  // Hold, load or rotate the stored site
  always_ff @(posedge clk) begin
    if (load_en) begin
      site_r <= load_site;
    end else if (shift_en) begin
      site_r <= next_site;
    end
  end

  assign site = site_r;

endmodule

/* hw/rtl/scns_dist_stage.sv */
// Squared corner offsets for the site at the head of the ring, registered.
module scns_dist_stage #(
  parameter int IW = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_in,
  input  logic [IW-1:0]          index_in,
  input  scns_pkg::scns_site_t   head_site,
  input  scns_pkg::scns_corners_t corners,
  output logic                   valid_out,
  output logic [IW-1:0]          index_out,
  output scns_pkg::scns_sq_t     sq_out
);
  import scns_pkg::*;

  logic                          valid_r;
  logic [IW-1:0]                 index_r;
  scns_sq_t                      sq_r;
  scns_sq_t                      sq_nxt;
  logic signed [CORNER_BITS-1:0] sx;
  logic signed [CORNER_BITS-1:0] sy;
  logic signed [CORNER_BITS-1:0] d_xlo, d_xhi, d_ylo, d_yhi;
  logic [MAG_BITS-1:0]           m_xlo, m_xhi, m_ylo, m_yhi;

  function automatic logic [MAG_BITS-1:0] mag(input logic signed [CORNER_BITS-1:0] d);
    logic signed [CORNER_BITS-1:0] neg;
    begin
      neg = -d;
      mag = d[CORNER_BITS-1] ? MAG_BITS'(neg) : MAG_BITS'(d);
    end
  endfunction

  // Offsets from the corner edges, their magnitudes and squares
  always_comb begin
    sx = $signed({2'b00, head_site.x});
    sy = $signed({2'b00, head_site.y});
    d_xlo = corners.lo_x - sx;
    d_xhi = corners.hi_x - sx;
    d_ylo = corners.lo_y - sy;
    d_yhi = corners.hi_y - sy;
    m_xlo = mag(d_xlo);
    m_xhi = mag(d_xhi);
    m_ylo = mag(d_ylo);
    m_yhi = mag(d_yhi);
    sq_nxt.sq_xlo = SQ_BITS'(m_xlo) * SQ_BITS'(m_xlo);
    sq_nxt.sq_xhi = SQ_BITS'(m_xhi) * SQ_BITS'(m_xhi);
    sq_nxt.sq_ylo = SQ_BITS'(m_ylo) * SQ_BITS'(m_ylo);
    sq_nxt.sq_yhi = SQ_BITS'(m_yhi) * SQ_BITS'(m_yhi);
    sq_nxt.color  = head_site.color;
  end

  // Mark the stage entry valid only for sites in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  // Capture squares, index and color
  always_ff @(posedge clk) begin
    index_r <= index_in;
    sq_r    <= sq_nxt;
  end

  assign valid_out = valid_r;
  assign index_out = index_r;
  assign sq_out    = sq_r;

endmodule

/* hw/rtl/scns_best_track.sv */
// Running nearest site for each of the four corners.
module scns_best_track #(
  parameter int IW = 4
) (
  input  logic                                       clk,
  input  logic                                       clear,
  input  logic                                       valid_in,
  input  logic [IW-1:0]                              index_in,
  input  scns_pkg::scns_sq_t                         sq_in,
  output logic [scns_pkg::NUM_CORNERS-1:0][IW-1:0]   best_idx,
  output logic [scns_pkg::NUM_CORNERS-1:0][scns_pkg::COLOR_BITS-1:0] best_color
);
  import scns_pkg::*;

  logic [NUM_CORNERS-1:0][DIST_BITS-1:0]  best_dist_r, best_dist_nxt;
  logic [NUM_CORNERS-1:0][IW-1:0]         best_idx_r, best_idx_nxt;
  logic [NUM_CORNERS-1:0][COLOR_BITS-1:0] best_color_r, best_color_nxt;
  logic [NUM_CORNERS-1:0][DIST_BITS-1:0]  corner_dist;

  // Sum squares per corner and keep the strictly smaller distance
  always_comb begin
    best_dist_nxt  = best_dist_r;
    best_idx_nxt   = best_idx_r;
    best_color_nxt = best_color_r;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      corner_dist[k] = DIST_BITS'(k[0] ? sq_in.sq_xhi : sq_in.sq_xlo)
                     + DIST_BITS'(k[1] ? sq_in.sq_yhi : sq_in.sq_ylo);
      if (clear) begin
        best_dist_nxt[k]  = '1;
        best_idx_nxt[k]   = '0;
        best_color_nxt[k] = '0;
      end else if (valid_in && (corner_dist[k] < best_dist_r[k])) begin
        best_dist_nxt[k]  = corner_dist[k];
        best_idx_nxt[k]   = index_in;
        best_color_nxt[k] = sq_in.color;
      end
    end
  end

  // Cleared at every scan start, so no reset needed
  always_ff @(posedge clk) begin
    best_dist_r  <= best_dist_nxt;
    best_idx_r   <= best_idx_nxt;
    best_color_r <= best_color_nxt;
  end

  assign best_idx   = best_idx_r;
  assign best_color = best_color_r;

endmodule

/* hw/rtl/sector_corner_nearest_site.sv */
// Top level: site ring, distance stage, corner trackers and scan sequencer.
//
// A load request (kind 0) writes one site entry; busy stays low. A scan request
// (kind 1) holds busy high: in ST_SCAN the site ring rotates once through all
// MAX_SITES cells, one site reaching the distance stage per cycle; ST_DRAIN
// finishes the last compare and ST_EMIT shows the result. The result is on
// out_res for exactly one cycle with out_valid high and cannot be held off, so
// the receiver must take it then. The user must write site_count through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it. A count
// of zero yields a result with valid_res low and all other fields zero.
module sector_corner_nearest_site #(
  parameter int MAX_SITES = scns_pkg::DEF_MAX_SITES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  scns_pkg::scns_in_t                in_req,
  output logic                              out_valid,
  output scns_pkg::scns_out_t               out_res,
  input  logic                              cfg_wr_en,
  input  logic [scns_pkg::COUNT_BITS-1:0]   cfg_wr_data
);
  import scns_pkg::*;

  localparam int IW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CW = $clog2(MAX_SITES + 1);

  scns_state_t               state_r, state_nxt;
  logic [COUNT_BITS-1:0]     site_count_r;
  logic [CW-1:0]             n_r, n_nxt;
  logic [IW-1:0]             step_r;
  scns_corners_t             corners_r, corners_nxt;

  logic                      accept;
  logic                      do_load;
  logic                      do_scan;
  logic                      stepping;
  logic                      last_step;

  scns_site_t                load_site;
  scns_site_t                ring [MAX_SITES];

  logic                      sq_valid;
  logic [IW-1:0]             sq_index;
  scns_sq_t                  sq;
  logic [NUM_CORNERS-1:0][IW-1:0]         best_idx;
  logic [NUM_CORNERS-1:0][COLOR_BITS-1:0] best_color;
  logic                      any_site;

  assign accept    = start && !busy;
  assign do_load   = accept && (in_req.kind == KIND_LOAD)
                     && (32'(in_req.site_slot) < MAX_SITES);
  assign do_scan   = accept && (in_req.kind == KIND_SCAN);
  assign last_step = (step_r == IW'(MAX_SITES - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (do_scan) state_nxt = ST_SCAN;
      ST_SCAN:  if (last_step) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy      = 1'b1;
    stepping  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_SCAN:  stepping = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  out_valid = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      site_count_r <= '0;
      step_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        site_count_r <= cfg_wr_data;
      end
      if (do_scan) begin
        step_r <= '0;
      end else if (stepping) begin
        step_r <= step_r + IW'(1);
      end
    end
  end

  // Latch corners and clamped site count at scan start
  always_comb begin
    corners_nxt.lo_x = $signed(CORNER_BITS'(in_req.center_x)) - $signed(CORNER_BITS'(in_req.radius));
    corners_nxt.hi_x = $signed(CORNER_BITS'(in_req.center_x)) + $signed(CORNER_BITS'(in_req.radius))
                       - CORNER_BITS'(1);
    corners_nxt.lo_y = $signed(CORNER_BITS'(in_req.center_y)) - $signed(CORNER_BITS'(in_req.radius));
    corners_nxt.hi_y = $signed(CORNER_BITS'(in_req.center_y)) + $signed(CORNER_BITS'(in_req.radius))
                       - CORNER_BITS'(1);
    if (32'(site_count_r) > MAX_SITES) begin
      n_nxt = CW'(MAX_SITES);
    end else begin
      n_nxt = CW'(site_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan) begin
      corners_r <= corners_nxt;
      n_r       <= n_nxt;
    end
  end

  // Site ring: cell 0 is the head, each cell takes its upper neighbor
  assign load_site.x     = in_req.site_x;
  assign load_site.y     = in_req.site_y;
  assign load_site.color = in_req.site_color;

  for (genvar k = 0; k < MAX_SITES; k++) begin : g_cell
    scns_site_cell u_cell (
      .clk       (clk),
      .load_en   (do_load && (32'(in_req.site_slot) == k)),
      .load_site (load_site),
      .shift_en  (stepping),
      .next_site (ring[(k + 1) % MAX_SITES]),
      .site      (ring[k])
    );
  end

  // Distance stage sees site step_r at the head
  scns_dist_stage #(
    .IW (IW)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (stepping && (32'(step_r) < 32'(n_r))),
    .index_in  (step_r),
    .head_site (ring[0]),
    .corners   (corners_r),
    .valid_out (sq_valid),
    .index_out (sq_index),
    .sq_out    (sq)
  );

  scns_best_track #(
    .IW (IW)
  ) u_best (
    .clk        (clk),
    .clear      (do_scan),
    .valid_in   (sq_valid),
    .index_in   (sq_index),
    .sq_in      (sq),
    .best_idx   (best_idx),
    .best_color (best_color)
  );

  // Form the result; zero every field when no site took part
  assign any_site = (n_r != '0);

  always_comb begin
    out_res           = '0;
    out_res.valid_res = any_site;
    if (any_site) begin
      out_res.nw_index = SLOT_BITS'(best_idx[0]);
      out_res.ne_index = SLOT_BITS'(best_idx[1]);
      out_res.sw_index = SLOT_BITS'(best_idx[2]);
      out_res.se_index = SLOT_BITS'(best_idx[3]);
      out_res.nw_color = best_color[0];
      out_res.ne_color = best_color[1];
      out_res.sw_color = best_color[2];
      out_res.se_color = best_color[3];
      out_res.all_same = (best_idx[0] == best_idx[1]) && (best_idx[1] == best_idx[2])
                         && (best_idx[2] == best_idx[3]);
    end
  end

endmodule
